@@ src/hla_pkg.sv @@
// Package with shared constants, types and the sine table for the Hough line accumulator.
`timescale 1ns / 1ps
package hla_pkg;
  localparam int RHO_BINS = 1024;
  localparam int THETA_BINS = 180;
  localparam int COORD_MAX = 255;
  localparam int STORE_SIZE = RHO_BINS * THETA_BINS;
  localparam int ADDR_W = $clog2(STORE_SIZE);
  localparam int RHO_W = $clog2(RHO_BINS);
  localparam int THETA_W = $clog2(THETA_BINS);
  localparam int CNT_W = 16;

  localparam logic [1:0] OP_VOTE = 2'd0;
  localparam logic [1:0] OP_FETCH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_DIAGONAL = 1'b1;

  typedef struct packed {
    logic load;
    logic vote_step;
    logic clr_step;
    logic scan_step;
    logic scan_rst;
    logic emit;
    logic emit_none;
  } hla_cmd_t;

  typedef struct packed {
    logic vote_last;
    logic clr_last;
    logic scan_end;
    logic scan_hit;
    logic pipe_busy;
  } hla_sts_t;

  function automatic logic [14:0] sin_q14(input logic [6:0] d);
    logic [14:0] r;
    unique case (d)
      7'd0: r=15'd0; 7'd1: r=15'd286; 7'd2: r=15'd572; 7'd3: r=15'd857; 7'd4: r=15'd1143;
      7'd5: r=15'd1428; 7'd6: r=15'd1713; 7'd7: r=15'd1997; 7'd8: r=15'd2280;
      7'd9: r=15'd2563; 7'd10: r=15'd2845; 7'd11: r=15'd3126; 7'd12: r=15'd3406;
      7'd13: r=15'd3686; 7'd14: r=15'd3964; 7'd15: r=15'd4240; 7'd16: r=15'd4516;
      7'd17: r=15'd4790; 7'd18: r=15'd5063; 7'd19: r=15'd5334; 7'd20: r=15'd5604;
      7'd21: r=15'd5872; 7'd22: r=15'd6138; 7'd23: r=15'd6402; 7'd24: r=15'd6664;
      7'd25: r=15'd6924; 7'd26: r=15'd7182; 7'd27: r=15'd7438; 7'd28: r=15'd7692;
      7'd29: r=15'd7943; 7'd30: r=15'd8192; 7'd31: r=15'd8438; 7'd32: r=15'd8682;
      7'd33: r=15'd8923; 7'd34: r=15'd9162; 7'd35: r=15'd9397; 7'd36: r=15'd9630;
      7'd37: r=15'd9860; 7'd38: r=15'd10087; 7'd39: r=15'd10311; 7'd40: r=15'd10531;
      7'd41: r=15'd10749; 7'd42: r=15'd10963; 7'd43: r=15'd11174; 7'd44: r=15'd11381;
      7'd45: r=15'd11585; 7'd46: r=15'd11786; 7'd47: r=15'd11982; 7'd48: r=15'd12176;
      7'd49: r=15'd12365; 7'd50: r=15'd12551; 7'd51: r=15'd12733; 7'd52: r=15'd12911;
      7'd53: r=15'd13085; 7'd54: r=15'd13255; 7'd55: r=15'd13421; 7'd56: r=15'd13583;
      7'd57: r=15'd13741; 7'd58: r=15'd13894; 7'd59: r=15'd14044; 7'd60: r=15'd14189;
      7'd61: r=15'd14330; 7'd62: r=15'd14466; 7'd63: r=15'd14598; 7'd64: r=15'd14726;
      7'd65: r=15'd14849; 7'd66: r=15'd14968; 7'd67: r=15'd15082; 7'd68: r=15'd15191;
      7'd69: r=15'd15296; 7'd70: r=15'd15396; 7'd71: r=15'd15491; 7'd72: r=15'd15582;
      7'd73: r=15'd15668; 7'd74: r=15'd15749; 7'd75: r=15'd15826; 7'd76: r=15'd15897;
      7'd77: r=15'd15964; 7'd78: r=15'd16026; 7'd79: r=15'd16083; 7'd80: r=15'd16135;
      7'd81: r=15'd16182; 7'd82: r=15'd16225; 7'd83: r=15'd16262; 7'd84: r=15'd16294;
      7'd85: r=15'd16322; 7'd86: r=15'd16344; 7'd87: r=15'd16362; 7'd88: r=15'd16374;
      7'd89: r=15'd16382; 7'd90: r=15'd16384;
      default: r = 15'd0;
    endcase
    return r;
  endfunction
endpackage

@@ src/hla_ctrl.sv @@
// Controller state machine sequencing vote, clear and scan operations.
`timescale 1ns / 1ps
module hla_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       in_opcode,
  input  logic [7:0]       in_pixel_value,
  input  hla_pkg::hla_sts_t sts,
  output hla_pkg::hla_cmd_t cmd,
  output logic             busy
);
  import hla_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_VOTE  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_CLEAR = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_WAIT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       clr_pend_r, clr_pend_nxt;
  logic       accept;

  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE) || clr_pend_r;

  always_comb begin
    state_nxt = state_r;
    clr_pend_nxt = clr_pend_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (clr_pend_r) begin
          state_nxt = ST_CLEAR;
          cmd.scan_rst = 1'b1;
        end else if (accept) begin
          cmd.load = 1'b1;
          if (in_opcode == OP_VOTE && in_pixel_value == 8'd255) begin
            state_nxt = ST_VOTE;
          end else if (in_opcode == OP_CLEAR) begin
            state_nxt = ST_CLEAR;
            cmd.scan_rst = 1'b1;
          end else if (in_opcode == OP_FETCH) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_VOTE: begin
        cmd.vote_step = 1'b1;
        if (sts.vote_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
          clr_pend_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (sts.scan_end) begin
          cmd.emit_none = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts.scan_hit) begin
          cmd.emit = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      clr_pend_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      clr_pend_r <= clr_pend_nxt;
    end
  end

  property p_vote_stays;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_VOTE && !sts.vote_last) |=> (state_r == ST_VOTE);
  endproperty
  a_vote_stays: assert property (p_vote_stays) else $error("vote sweep left early");

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != ST_IDLE) |-> !cmd.load;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("load while busy");

  property p_emit_excl;
    @(posedge clk) disable iff (!rst_n) !(cmd.emit && cmd.emit_none);
  endproperty
  a_emit_excl: assert property (p_emit_excl) else $error("double result");
endmodule

@@ src/hla_dp.sv @@
// Datapath with the vote memory, rho computation, clear sweep and peak scan.
`timescale 1ns / 1ps
module hla_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  hla_pkg::hla_cmd_t cmd,
  output hla_pkg::hla_sts_t sts,
  input  logic [7:0]        in_pixel_x,
  input  logic [7:0]        in_pixel_y,
  input  logic [15:0]       thr,
  input  logic [8:0]        diag,
  output logic              out_strobe,
  output logic              out_peak_found,
  output logic signed [9:0] out_peak_rho,
  output logic signed [7:0] out_peak_theta,
  output logic [15:0]       out_peak_votes
);
  import hla_pkg::*;

  logic [CNT_W-1:0] mem [STORE_SIZE];

  logic [7:0] x_r, y_r;
  logic [THETA_W-1:0] t_r, t_nxt;
  logic [ADDR_W:0] pos_r, pos_nxt;
  logic [RHO_W-1:0] srow_r;
  logic [THETA_W-1:0] scol_r;

  // Vote pipeline: stage 1 angle and products; stage 2 rounded row; stage 3 address;
  // stage 4 read; stage 5 write.
  logic s1_v_r, sr_v_r, s2_v_r, s3_v_r;
  logic signed [24:0] pc_r, ps_r;
  logic [THETA_W-1:0] s1_t_r, sr_t_r;
  logic signed [13:0] row_r;
  logic [ADDR_W-1:0] s2_a_r, s3_a_r;
  logic [CNT_W-1:0] rd_r;
  logic fwd;

  logic [6:0] cdeg, sdeg;
  logic signed [15:0] cval, sval;
  logic [8:0] a;
  always_comb begin
    // angle t-90; cos = sin(t), sin(t-90) = -cos(t) = -sin(90-t) magnitude
    a = {1'b0, t_r};
    if (a <= 9'd90) begin
      cdeg = a[6:0];
      sdeg = 7'(9'd90 - a);
      cval = $signed({1'b0, sin_q14(cdeg)});
      sval = -$signed({1'b0, sin_q14(sdeg)});
    end else begin
      cdeg = 7'(9'd180 - a);
      sdeg = 7'(a - 9'd90);
      cval = $signed({1'b0, sin_q14(cdeg)});
      sval = $signed({1'b0, sin_q14(sdeg)});
    end
  end

  // Halves round away from zero: a bias of 8192 above zero and 8191 below it, then a floor.
  logic signed [25:0] acc;
  logic signed [26:0] rsum;
  logic signed [13:0] row;
  logic [ADDR_W-1:0] addr2;
  always_comb begin
    acc = 26'(pc_r) + 26'(ps_r);
    rsum = 27'(acc) + (acc[25] ? 27'sd8191 : 27'sd8192) + $signed({4'd0, diag, 14'd0});
    row = 14'(rsum >>> 14);
    addr2 = ADDR_W'(ADDR_W'(row_r[RHO_W-1:0]) * ADDR_W'(THETA_BINS) + ADDR_W'(sr_t_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; sr_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.vote_step;
      sr_v_r <= s1_v_r;
      s2_v_r <= sr_v_r && row_r >= 0 && row_r < 14'(RHO_BINS);
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    pc_r <= 25'($signed({1'b0, x_r}) * cval);
    ps_r <= 25'($signed({1'b0, y_r}) * sval);
    s1_t_r <= t_r;
    row_r <= row;
    sr_t_r <= s1_t_r;
    s2_a_r <= addr2;
    s3_a_r <= s2_a_r;
  end

  logic [CNT_W-1:0] cur;
  assign fwd = s3_v_r && s2_v_r && (s3_a_r == s2_a_r);
  assign cur = rd_r;

  logic [ADDR_W-1:0] raddr;
  logic [CNT_W-1:0] inc;
  assign inc = (cur == '1) ? cur : cur + 1'b1;
  assign raddr = cmd.scan_step ? pos_r[ADDR_W-1:0] : s2_a_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_step) mem[pos_r[ADDR_W-1:0]] <= '0;
    else if (s3_v_r) mem[s3_a_r] <= inc;
    rd_r <= (fwd) ? inc : mem[raddr];
  end

  always_comb begin
    t_nxt = t_r;
    pos_nxt = pos_r;
    if (cmd.load) t_nxt = '0;
    else if (cmd.vote_step) t_nxt = t_r + 1'b1;
    if (cmd.scan_rst) pos_nxt = '0;
    else if (cmd.clr_step) pos_nxt = sts.clr_last ? '0 : pos_r + 1'b1;
    else if (cmd.scan_step) pos_nxt = pos_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; t_r <= '0; srow_r <= '0; scol_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      t_r <= t_nxt;
      if (cmd.scan_rst) begin
        srow_r <= '0; scol_r <= '0;
      end else if (cmd.clr_step && sts.clr_last) begin
        srow_r <= '0; scol_r <= '0;
      end else if (cmd.emit || (cmd.scan_step == 1'b0 && sts.scan_hit == 1'b0 && 1'b0)) begin
        srow_r <= srow_r;
      end
      if (cmd.scan_step) begin
        if (scol_r == THETA_W'(THETA_BINS - 1)) begin
          scol_r <= '0; srow_r <= srow_r + 1'b1;
        end else scol_r <= scol_r + 1'b1;
      end
    end
  end

  logic [RHO_W-1:0] hrow_r;
  logic [THETA_W-1:0] hcol_r;
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      hrow_r <= srow_r; hcol_r <= scol_r;
    end
    if (cmd.load) begin
      x_r <= in_pixel_x; y_r <= in_pixel_y;
    end
  end

  assign sts.vote_last = (t_r == THETA_W'(THETA_BINS - 1));
  assign sts.clr_last = (pos_r == (ADDR_W + 1)'(STORE_SIZE - 1));
  assign sts.scan_end = (pos_r >= (ADDR_W + 1)'(STORE_SIZE));
  assign sts.scan_hit = (rd_r > thr);
  assign sts.pipe_busy = s1_v_r || sr_v_r || s2_v_r || s3_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else out_strobe <= cmd.emit || cmd.emit_none;
    out_peak_found <= cmd.emit;
    out_peak_rho <= cmd.emit ? $signed(10'({1'b0, hrow_r} - {2'b0, diag})) : '0;
    out_peak_theta <= cmd.emit ? $signed(8'({1'b0, hcol_r} - 9'd90)) : '0;
    out_peak_votes <= cmd.emit ? rd_r : '0;
  end

  property p_clr_no_vote;
    @(posedge clk) disable iff (!rst_n) cmd.clr_step |-> !s3_v_r;
  endproperty
  a_clr_no_vote: assert property (p_clr_no_vote) else $error("clear during vote");

  property p_hit_bound;
    @(posedge clk) disable iff (!rst_n) cmd.scan_step |-> !sts.scan_end;
  endproperty
  a_hit_bound: assert property (p_hit_bound) else $error("scan beyond end");

  property p_strobe_one;
    @(posedge clk) disable iff (!rst_n) out_strobe |=> !out_strobe;
  endproperty
  a_strobe_one: assert property (p_strobe_one) else $error("result held two cycles");
endmodule

@@ src/hough_line_accumulator.sv @@
// Top level of the Hough line accumulator: config registers, controller and datapath.
//   channel   direction  handshake        payload
//   in_       input      start / busy     opcode, pixel_x, pixel_y, pixel_value
//   out_      output     out_strobe       peak_found, peak_rho, peak_theta, peak_votes
//   cfg_      input      cfg_we           cfg_index, cfg_data
// A voting word with pixel_value 255 steps through the 180 theta bins, one memory read-modify-write
// per in-range bin, then waits for the vote pipeline to drain.
// A clear word sweeps all 184320 bins, one per cycle; the same sweep runs after reset with busy high.
// A fetch word examines bins in turn: it reads each bin, then compares it with the threshold.
// The result is shown for exactly one cycle on out_strobe; the receiver cannot stall.
`timescale 1ns / 1ps
module hough_line_accumulator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [7:0]        in_pixel_x,
  input  logic [7:0]        in_pixel_y,
  input  logic [7:0]        in_pixel_value,
  output logic              out_strobe,
  output logic              out_peak_found,
  output logic signed [9:0] out_peak_rho,
  output logic signed [7:0] out_peak_theta,
  output logic [15:0]       out_peak_votes,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data
);
  import hla_pkg::*;

  logic [15:0] thr_r;
  logic [8:0] diag_r;
  hla_cmd_t cmd;
  hla_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd160;
      diag_r <= 9'd362;
    end else if (cfg_we) begin
      if (cfg_index == CFG_THRESHOLD) thr_r <= cfg_data;
      else if (cfg_index == CFG_DIAGONAL) diag_r <= cfg_data[8:0];
    end
  end

  hla_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_opcode(in_opcode),
    .in_pixel_value(in_pixel_value), .sts(sts), .cmd(cmd), .busy(busy)
  );

  hla_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y), .thr(thr_r), .diag(diag_r),
    .out_strobe(out_strobe), .out_peak_found(out_peak_found),
    .out_peak_rho(out_peak_rho), .out_peak_theta(out_peak_theta),
    .out_peak_votes(out_peak_votes)
  );
endmodule

@@ tb/hough_line_accumulator_tb.sv @@
// Self-checking testbench for the Hough line accumulator with a built-in vote predictor.
`timescale 1ns / 1ps
module hough_line_accumulator_tb;
  import hla_pkg::*;

  typedef struct packed {
    logic       found;
    logic [9:0] rho;
    logic [7:0] theta;
    logic [15:0] votes;
  } peak_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] v;
    logic       typed;
    peak_t      want;
  } plan_row_t;

  localparam int SINE_Q14 [91] = '{
    0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
    2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
    5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
    8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_opcode;
  logic [7:0] in_pixel_x;
  logic [7:0] in_pixel_y;
  logic [7:0] in_pixel_value;
  logic out_strobe;
  logic out_peak_found;
  logic signed [9:0] out_peak_rho;
  logic signed [7:0] out_peak_theta;
  logic [15:0] out_peak_votes;
  logic cfg_we;
  logic cfg_index;
  logic [15:0] cfg_data;

  logic [15:0] vote_tally [STORE_SIZE];
  int unsigned scan_ptr;
  int unsigned thr_q;
  int unsigned diag_q;
  peak_t pending_peaks[$];
  int errors;
  int burst_left;
  plan_row_t plan [13];

  hough_line_accumulator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .in_pixel_value(in_pixel_value), .out_strobe(out_strobe),
    .out_peak_found(out_peak_found), .out_peak_rho(out_peak_rho),
    .out_peak_theta(out_peak_theta), .out_peak_votes(out_peak_votes),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic longint sine_deg(input int unsigned deg);
    int unsigned d;
    d = deg % 360;
    if (d <= 90) return SINE_Q14[d];
    if (d <= 180) return SINE_Q14[180 - d];
    if (d <= 270) return -SINE_Q14[d - 180];
    return -SINE_Q14[360 - d];
  endfunction

  task automatic clear_tally();
    for (int i = 0; i < STORE_SIZE; i++) vote_tally[i] = '0;
    scan_ptr = 0;
  endtask

  task automatic predict_word(input logic [1:0] op, input logic [7:0] x, input logic [7:0] y,
                              input logic [7:0] v, output bit emits, output peak_t p);
    longint acc;
    longint mag;
    longint row;
    int unsigned idx;
    emits = 0;
    p = '0;
    if (op == OP_VOTE && v == 8'd255) begin
      for (int t = 0; t < THETA_BINS; t++) begin
        acc = longint'(x) * sine_deg(t + 360) + longint'(y) * sine_deg(t + 270);
        mag = (acc < 0) ? -acc : acc;
        mag = (mag + 8192) >>> 14;
        row = ((acc < 0) ? -mag : mag) + diag_q;
        if (row >= 0 && row < RHO_BINS) begin
          idx = row * THETA_BINS + t;
          if (vote_tally[idx] != 16'hFFFF) vote_tally[idx]++;
        end
      end
    end else if (op == OP_CLEAR) begin
      clear_tally();
    end else if (op == OP_FETCH) begin
      emits = 1;
      while (scan_ptr < STORE_SIZE && !p.found) begin
        idx = scan_ptr;
        scan_ptr++;
        if (vote_tally[idx] > thr_q) begin
          p.found = 1'b1;
          p.rho = 10'(int'(idx / THETA_BINS) - int'(diag_q));
          p.theta = 8'(int'(idx % THETA_BINS) - 90);
          p.votes = vote_tally[idx];
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_peaks.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        peak_t w;
        w = pending_peaks.pop_front();
        if (out_peak_found !== w.found) report_mismatch("found", out_peak_found, w.found);
        if (out_peak_rho !== w.rho) report_mismatch("rho", out_peak_rho, $signed(w.rho));
        if (out_peak_theta !== w.theta)
          report_mismatch("theta", out_peak_theta, $signed(w.theta));
        if (out_peak_votes !== w.votes) report_mismatch("votes", out_peak_votes, w.votes);
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [7:0] x, input logic [7:0] y,
                           input logic [7:0] v, input logic typed, input peak_t want);
    bit emits;
    peak_t p;
    if (burst_left <= 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 1000 : $urandom_range(1, 30);
    end
    start = 1'b1;
    in_opcode = op;
    in_pixel_x = x;
    in_pixel_y = y;
    in_pixel_value = v;
    do @(posedge clk); while (busy);
    predict_word(op, x, y, v, emits, p);
    if (emits) pending_peaks.push_back(typed ? want : p);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic settle();
    start = 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (200) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value[15:0];
    if (idx == CFG_THRESHOLD) thr_q = value & 16'hFFFF;
    else diag_q = value & 9'h1FF;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [1:0] op;
    logic [7:0] v;
    int unsigned pick;
    peak_t none;
    none = '0;
    errors = 0;
    burst_left = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_VOTE;
    in_pixel_x = '0;
    in_pixel_y = '0;
    in_pixel_value = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data = '0;
    thr_q = 160;
    diag_q = 362;
    clear_tally();
    plan = '{
      '{OP_VOTE,   8'd0,   8'd0,   8'd255, 1'b0, '0},
      '{OP_VOTE,   8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{OP_VOTE,   8'd128, 8'd64,  8'd254, 1'b0, '0},
      '{OP_UNUSED, 8'd255, 8'd255, 8'd255, 1'b0, '0},
      '{OP_FETCH,  8'd0,   8'd0,   8'd0,   1'b1, '{1'b1, 10'd0, -8'sd90, 16'd1}},
      '{OP_FETCH,  8'd0,   8'd0,   8'd0,   1'b1, '{1'b1, 10'd0, -8'sd89, 16'd1}},
      '{OP_FETCH,  8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{OP_CLEAR,  8'd0,   8'd0,   8'd0,   1'b0, '0},
      '{OP_VOTE,   8'd0,   8'd0,   8'd255, 1'b0, '0},
      '{OP_VOTE,   8'd255, 8'd0,   8'd255, 1'b0, '0},
      '{OP_FETCH,  8'd0,   8'd0,   8'd0,   1'b1, '{1'b1, 10'd0, -8'sd90, 16'd2}},
      '{OP_VOTE,   8'd0,   8'd255, 8'd255, 1'b0, '0},
      '{OP_FETCH,  8'd0,   8'd0,   8'd0,   1'b0, '0}
    };
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    settle();
    write_reg(CFG_THRESHOLD, 0);
    write_reg(CFG_DIAGONAL, 0);
    foreach (plan[i]) send_word(plan[i].op, plan[i].x, plan[i].y, plan[i].v,
                                plan[i].typed, plan[i].want);
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin write_reg(CFG_DIAGONAL, 0); write_reg(CFG_THRESHOLD, 1); end
        1: begin write_reg(CFG_DIAGONAL, 362); write_reg(CFG_THRESHOLD, 0); end
        2: begin write_reg(CFG_DIAGONAL, 511); write_reg(CFG_THRESHOLD, $urandom_range(0, 3)); end
        default: begin
          write_reg(CFG_DIAGONAL, $urandom_range(0, 511));
          write_reg(CFG_THRESHOLD, 2);
        end
      endcase
      for (int n = 0; n < 410; n++) begin
        pick = $urandom_range(0, 99);
        op = (pick < 8) ? OP_FETCH : (pick < 11) ? OP_UNUSED : OP_VOTE;
        v = ($urandom_range(0, 99) < 85) ? 8'd255 : 8'($urandom);
        send_word(op, 8'($urandom), 8'($urandom), v, 1'b0, none);
      end
    end
    settle();
    write_reg(CFG_THRESHOLD, 65535);
    send_word(OP_FETCH, 8'd0, 8'd0, 8'd0, 1'b1, none);
    send_word(OP_FETCH, 8'd255, 8'd255, 8'd255, 1'b1, none);
    start = 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
